// ===== rtl/core/grayscale_histogram_engine_defines.svh =====
// assertion macros shared by the histogram engine modules
`ifndef GRAYSCALE_HISTOGRAM_ENGINE_DEFINES_SVH
`define GRAYSCALE_HISTOGRAM_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define GHE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("histogram engine check failed");
// checked at every edge, reset included
`define GHE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("histogram engine check failed");
`else
`define GHE_ASSERT(lbl, prop)
`define GHE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/core/ghe_pkg.sv =====
// types, constants and helpers of the grayscale histogram engine
package ghe_pkg;

  localparam int unsigned NUM_BINS    = 256;
  localparam int unsigned COUNT_WIDTH = 20;
  localparam int unsigned BIN_AW      = $clog2(NUM_BINS);
  localparam int unsigned VALUE_W     = 8;
  localparam int unsigned OUT_W       = 20;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [VALUE_W-1:0] value;
  } ghe_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] bin_count;
    logic [OUT_W-1:0] peak_count;
  } ghe_out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic issue;     // latch the beat and read its bin
    logic clear;     // drop every bin and the peak
    logic write;     // write back the incremented count
    logic load_out;  // load the result register
  } ghe_cmd_t;

  function automatic logic [BIN_AW-1:0] bin_index(input logic [VALUE_W-1:0] value);
    return BIN_AW'(value);
  endfunction

  function automatic logic in_range(input logic [VALUE_W-1:0] value);
    return 32'(value) < NUM_BINS;
  endfunction

endpackage

// ===== rtl/core/ghe_ctrl.sv =====
// controller state machine of the histogram engine
`include "grayscale_histogram_engine_defines.svh"

module ghe_ctrl
  import ghe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  input  logic       out_stall,
  output logic       in_stall,
  output logic       out_valid,
  output ghe_cmd_t   cmd
);

  typedef enum logic {S_IDLE, S_LOOKUP} state_t;

  state_t state_r, state_nxt;
  logic   pend_add_r, pend_add_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    pend_add_nxt  = pend_add_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_ADD, OP_READ: begin
              cmd.issue    = 1'b1;
              pend_add_nxt = (in_op == OP_ADD);
              state_nxt    = S_LOOKUP;
            end
            OP_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_LOOKUP: begin
        if (pend_add_r) begin
          cmd.write = 1'b1;
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_add_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_add_r  <= pend_add_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `GHE_ASSERT(a_lookup_follows_issue, cmd.issue |=> state_r == S_LOOKUP)
  `GHE_ASSERT(a_result_from_lookup, $rose(out_valid_r) |-> $past(state_r == S_LOOKUP))
  `GHE_ASSERT_ALWAYS(a_one_command, $onehot0({cmd.issue, cmd.clear, cmd.write, cmd.load_out}))

endmodule

// ===== rtl/core/ghe_datapath.sv =====
// bin memory, peak register and result register of the histogram engine
`include "grayscale_histogram_engine_defines.svh"

module ghe_datapath
  import ghe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  ghe_cmd_t cmd,
  input  ghe_in_t  in_data,
  output ghe_out_t out_data
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]    valid_r;
  logic [COUNT_WIDTH-1:0] peak_r;
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic [BIN_AW-1:0]      idx_r;
  logic                   ok_r;
  logic                   hit_r;
  ghe_out_t               out_r;

  logic [BIN_AW-1:0]      idx;
  logic                   idx_ok;
  logic [COUNT_WIDTH-1:0] cur_count;
  logic [COUNT_WIDTH-1:0] inc_count;

  assign idx       = bin_index(in_data.value);
  assign idx_ok    = in_range(in_data.value);
  assign cur_count = hit_r ? rd_data_r : '0;
  assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_WIDTH'(1);

  // bin store
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= mem[idx];
    end
    if (cmd.write && ok_r) begin
      mem[idx_r] <= inc_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      idx_r <= idx;
      ok_r  <= idx_ok;
      hit_r <= idx_ok && valid_r[idx];
    end
    if (cmd.load_out) begin
      out_r.bin_count  <= OUT_W'(cur_count);
      out_r.peak_count <= OUT_W'(peak_r);
    end
  end

  // a bin not written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      peak_r  <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
      peak_r  <= '0;
    end else if (cmd.write && ok_r) begin
      valid_r[idx_r] <= 1'b1;
      if (inc_count > peak_r) begin
        peak_r <= inc_count;
      end
    end
  end

  assign out_data = out_r;

  `GHE_ASSERT(a_clear_zeroes_peak, cmd.clear |=> peak_r == '0)
  `GHE_ASSERT(a_clear_drops_bins, cmd.clear |=> valid_r == '0)
  `GHE_ASSERT(a_peak_covers_write, cmd.write && ok_r |=> peak_r >= $past(inc_count))

endmodule

// ===== rtl/core/grayscale_histogram_engine.sv =====
// top level of the grayscale histogram engine
// 256-bin histogram of 8-bit gray levels with 20-bit saturating counts and a
// running peak. each input beat carries a command: add bumps the bin named by
// value (holding at the maximum count), read returns that bin's count with the
// current peak as one result beat, clear empties every bin and the peak, and
// the unused code is dropped. add and read each go through the registered
// read of the bin memory followed by the write-back or result load;
// clear and the unused code need no lookup. in_stall stays high while a lookup
// is in flight. a finished read result waits in an output register, so the
// next command is taken while out_stall holds it; a read only stalls if it
// finishes while the previous result is still waiting. the bins are cleared by
// per-bin valid flags, so neither reset nor clear needs a sweep of the memory
module grayscale_histogram_engine
  import ghe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  // command beats
  input  logic     in_valid,
  output logic     in_stall,
  input  ghe_in_t  in_data,
  // result beats
  output logic     out_valid,
  input  logic     out_stall,
  output ghe_out_t out_data
);

  ghe_cmd_t cmd;

  // sequencing of lookup, write-back and result hand-off
  ghe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // bin memory, peak and result register
  ghe_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
